FILE: rtl/tnpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trajectory nearest point query package
// Shared opcodes, status codes, register indexes and scan cell record.
// ----------------------------------------------------------------------------
package tnpq_pkg;

    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_APPEND   = 3'd1;
    localparam logic [2:0] OP_NEAR_POS = 3'd2;
    localparam logic [2:0] OP_REL_TIME = 3'd3;
    localparam logic [2:0] OP_ABS_TIME = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [0:0] REG_HEADER_TIME  = 1'b0;
    localparam logic [0:0] REG_FORWARD_ONLY = 1'b1;

    // one stored point streamed through the scan cells
    typedef struct packed {
        logic        vld;
        logic        first;
        logic        last;
        logic [16:0] idx;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pt;
    } t_pt;

endpackage
`default_nettype wire

FILE: rtl/tnpq_sq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trajectory nearest point query square cell
// Registered absolute difference and square of both coordinates.
// ----------------------------------------------------------------------------
module tnpq_sq_cell
    import tnpq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_pt         i_pt,
    input  wire logic [31:0] i_qx,
    input  wire logic [31:0] i_qy,
    output t_pt              o_pt,
    output logic [63:0]      o_sx,
    output logic [63:0]      o_sy
);
    t_pt         r_pt;
    logic [31:0] r_dx;
    logic [31:0] r_dy;
    logic [63:0] r_sx;
    logic [63:0] r_sy;
    t_pt         r_pt2;
    logic [32:0] n_dx;
    logic [32:0] n_dy;

    always_comb begin
        n_dx = {i_pt.px[31], i_pt.px} - {i_qx[31], i_qx};
        n_dy = {i_pt.py[31], i_pt.py} - {i_qy[31], i_qy};
        if (n_dx[32]) n_dx = 33'd0 - n_dx;
        if (n_dy[32]) n_dy = 33'd0 - n_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt.vld  <= 1'b0;
            r_pt2.vld <= 1'b0;
        end else begin
            r_pt  <= i_pt;
            r_pt2 <= r_pt;
        end
        r_dx <= n_dx[31:0];
        r_dy <= n_dy[31:0];
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
    end

    assign o_pt = r_pt2;
    assign o_sx = r_sx;
    assign o_sy = r_sy;
endmodule
`default_nettype wire

FILE: rtl/tnpq_min_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trajectory nearest point query min cell
// Sums squared distances and keeps the first running minimum.
// ----------------------------------------------------------------------------
module tnpq_min_cell
    import tnpq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_pt         i_pt,
    input  wire logic [63:0] i_sx,
    input  wire logic [63:0] i_sy,
    output logic             o_done,
    output t_pt              o_best
);
    t_pt         r_pt;
    logic [64:0] r_d;
    logic [64:0] r_bd;
    t_pt         r_best;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt.vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pt   <= i_pt;
            r_done <= r_pt.vld && r_pt.last;
        end
        r_d <= {1'b0, i_sx} + {1'b0, i_sy};
        if (r_pt.vld && (r_pt.first || r_d < r_bd)) begin
            r_bd   <= r_d;
            r_best <= r_pt;
        end
    end

    assign o_done = r_done;
    assign o_best = r_best;
endmodule
`default_nettype wire

FILE: rtl/tnpq_time_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trajectory nearest point query time cell
// Lower-bound scan over times with neighbor pick and end clamping.
// ----------------------------------------------------------------------------
module tnpq_time_cell
    import tnpq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_pt         i_pt,
    input  wire logic [31:0] i_qt,
    input  wire logic        i_fwd,
    output logic             o_done,
    output t_pt              o_best
);
    t_pt  r_prev;
    t_pt  r_best;
    logic r_found;
    logic r_done;
    logic n_ge;
    logic signed [32:0] n_after;
    logic signed [32:0] n_before;

    always_comb begin
        n_ge     = $signed(i_pt.pt) >= $signed(i_qt);
        n_after  = $signed({i_pt.pt[31], i_pt.pt}) - $signed({i_qt[31], i_qt});
        n_before = $signed({i_qt[31], i_qt}) - $signed({r_prev.pt[31], r_prev.pt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_pt.vld && i_pt.last;
            if (i_pt.vld) begin
                if (i_pt.first) r_found <= 1'b0;
                if ((i_pt.first || !r_found) && n_ge) r_found <= 1'b1;
            end
        end
        if (i_pt.vld) begin
            r_prev <= i_pt;
            if (i_pt.first || !r_found) begin
                if (n_ge) begin
                    if (i_pt.first || i_fwd || n_after < n_before) r_best <= i_pt;
                    else r_best <= r_prev;
                end else begin
                    r_best <= i_pt;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_best = r_best;
endmodule
`default_nettype wire

FILE: rtl/trajectory_nearest_point_query_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trajectory nearest point query unit
// Point table with nearest position and time lower-bound queries.
// ----------------------------------------------------------------------------
// channel   dir  handshake               content
// s_axis    in   i_s_axis_tvalid/tready  opcode, pos_x, pos_y, time_value
// m_axis    out  o_m_axis_tvalid/tready  status, match_index, x, y, time
// cfg       in   i_cfg_valid/o_cfg_ready register index, write data
// Clear, append and unused opcodes skip the scan and go straight to S_OUT.
// Position and time queries scan the table: the table memory streams one point
// a cycle into the square, min and time cells, so the scan length grows with
// the count, up to MAX_POINTS.
// One request at a time; a new one is taken the cycle after the result is taken.
// Synchronous active-low reset clears count, registers and control.
module trajectory_nearest_point_query_unit
    import tnpq_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [2:0] opcode, [34:3] pos_x, [66:35] pos_y, [98:67] time_value, zero fill
    input  wire logic [103:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [1:0] status, [12:2] match_index, [44:13] x, [76:45] y, [108:77] time
    output logic [111:0]      o_m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_OUT} t_state;

    logic [31:0] r_mem_x [MAX_POINTS];
    logic [31:0] r_mem_y [MAX_POINTS];
    logic [31:0] r_mem_t [MAX_POINTS];

    t_state      r_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_addr;
    logic [31:0] r_hdr;
    logic        r_fwd;
    logic [2:0]  r_op;
    logic [31:0] r_qx;
    logic [31:0] r_qy;
    logic [31:0] r_qt;
    t_pt         r_rd;
    logic [111:0] r_out;

    logic [2:0]  w_op;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [31:0] w_t;
    logic signed [32:0] w_q;
    logic [31:0] w_qsat;
    logic        w_acc;
    t_pt         w_sq_pt;
    logic [63:0] w_sx;
    logic [63:0] w_sy;
    logic        w_mdone;
    t_pt         w_mbest;
    logic        w_tdone;
    t_pt         w_tbest;
    t_pt         w_sel;
    logic        w_done;

    assign w_op = i_s_axis_tdata[2:0];
    assign w_x  = i_s_axis_tdata[34:3];
    assign w_y  = i_s_axis_tdata[66:35];
    assign w_t  = i_s_axis_tdata[98:67];
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !o_m_axis_tvalid;
    assign o_cfg_ready = 1'b1;
    assign o_m_axis_tdata = r_out;

    always_comb begin
        w_q = $signed({w_t[31], w_t}) - $signed({r_hdr[31], r_hdr});
        if (w_q[32] != w_q[31]) w_qsat = w_q[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        else w_qsat = w_q[31:0];
    end

    tnpq_sq_cell u_sq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(r_rd), .i_qx(r_qx), .i_qy(r_qy),
        .o_pt(w_sq_pt), .o_sx(w_sx), .o_sy(w_sy)
    );
    tnpq_min_cell u_min (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(w_sq_pt), .i_sx(w_sx), .i_sy(w_sy),
        .o_done(w_mdone), .o_best(w_mbest)
    );
    tnpq_time_cell u_time (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(r_rd), .i_qt(r_qt), .i_fwd(r_fwd),
        .o_done(w_tdone), .o_best(w_tbest)
    );

    assign w_sel  = (r_op == OP_NEAR_POS) ? w_mbest : w_tbest;
    assign w_done = (r_op == OP_NEAR_POS) ? w_mdone : w_tdone;

    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == OP_APPEND && r_cnt < CW'(MAX_POINTS)) begin
            r_mem_x[r_cnt[AW-1:0]] <= w_x;
            r_mem_y[r_cnt[AW-1:0]] <= w_y;
            r_mem_t[r_cnt[AW-1:0]] <= w_t;
        end
        r_rd.px <= r_mem_x[r_addr[AW-1:0]];
        r_rd.py <= r_mem_y[r_addr[AW-1:0]];
        r_rd.pt <= r_mem_t[r_addr[AW-1:0]];
        r_rd.idx <= 17'(r_addr);
        r_rd.first <= (r_addr == '0);
        r_rd.last <= (r_addr == r_cnt - 1'b1);
        r_rd.vld <= i_rst_n && (r_state == S_SCAN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_hdr   <= '0;
            r_fwd   <= 1'b0;
            r_addr  <= '0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HEADER_TIME:  r_hdr <= i_cfg_data;
                    REG_FORWARD_ONLY: r_fwd <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) o_m_axis_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op <= w_op;
                        r_qx <= w_x;
                        r_qy <= w_y;
                        r_qt <= (w_op == OP_ABS_TIME) ? w_qsat : w_t;
                        r_addr <= '0;
                        r_out <= '0;
                        if (w_op == OP_NEAR_POS || w_op == OP_REL_TIME ||
                            w_op == OP_ABS_TIME) begin
                            if (r_cnt == '0) begin
                                r_out[1:0] <= ST_EMPTY;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_state <= S_OUT;
                            if (w_op == OP_CLEAR) begin
                                r_cnt <= '0;
                            end else if (w_op == OP_APPEND) begin
                                if (r_cnt < CW'(MAX_POINTS)) begin
                                    r_cnt <= r_cnt + 1'b1;
                                    r_out[12:2] <= 11'(r_cnt + 1'b1);
                                end else begin
                                    r_out[1:0] <= ST_FULL;
                                    r_out[12:2] <= 11'(r_cnt);
                                end
                            end else begin
                                r_out[12:2] <= 11'(r_cnt);
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == r_cnt - 1'b1) r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_out[1:0]    <= ST_OK;
                        r_out[12:2]   <= 11'(w_sel.idx);
                        r_out[44:13]  <= w_sel.px;
                        r_out[76:45]  <= w_sel.py;
                        r_out[108:77] <= w_sel.pt;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_m_axis_tvalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
